### sv/capacitive_dispense_controller_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the capacitive dispense controller
// Shared concurrent-assertion wrappers, clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef CAPACITIVE_DISPENSE_CONTROLLER_TOP_DEFINES_SVH
`define CAPACITIVE_DISPENSE_CONTROLLER_TOP_DEFINES_SVH

// checked outside reset only
`define CDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every edge, reset included
`define CDC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### sv/cdc_pkg.sv
// ----------------------------------------------------------------------------
// cdc_pkg
// Types and constants shared by the capacitive dispense controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdc_pkg;

   // event codes on the request channel
   typedef enum logic [1:0] {
      OP_MEASURE = 2'd0,
      OP_PWM     = 2'd1,
      OP_SENSE   = 2'd2,
      OP_COMMAND = 2'd3
   } opcode_type;

   // servo positions
   typedef enum logic [1:0] {
      POS_CLOSED = 2'd0,
      POS_HALF   = 2'd1,
      POS_OPEN   = 2'd2
   } position_type;

   // host command bytes (ASCII)
   localparam logic [7:0] CMD_DISPENSE = 8'h44;  // D
   localparam logic [7:0] CMD_CLOSE    = 8'h43;  // C
   localparam logic [7:0] CMD_OPEN     = 8'h4F;  // O
   localparam logic [7:0] CMD_HALF     = 8'h48;  // H
   localparam logic [7:0] CMD_MEASURE  = 8'h4D;  // M
   localparam logic [7:0] CMD_GET      = 8'h47;  // G
   localparam logic [7:0] CMD_START    = 8'h53;  // S
   localparam logic [7:0] CMD_END      = 8'h45;  // E

   // register indexes on the csr port
   localparam logic [2:0] CSR_CLOSED_PULSE = 3'd0;
   localparam logic [2:0] CSR_HALF_PULSE   = 3'd1;
   localparam logic [2:0] CSR_OPEN_PULSE   = 3'd2;
   localparam logic [2:0] CSR_PWM_PERIOD   = 3'd3;
   localparam logic [2:0] CSR_SAMPLE_EDGES = 3'd4;

   // reset values
   localparam logic [7:0]  RST_CLOSED_PULSE = 8'd21;
   localparam logic [7:0]  RST_HALF_PULSE   = 8'd14;
   localparam logic [7:0]  RST_OPEN_PULSE   = 8'd7;
   localparam logic [7:0]  RST_PWM_PERIOD   = 8'd200;
   localparam logic [15:0] RST_SAMPLE_EDGES = 16'd500;
   localparam logic [15:0] RST_WANTED       = 16'd31;

   typedef struct packed {
      logic [7:0]  closed_pulse;
      logic [7:0]  half_pulse;
      logic [7:0]  open_pulse;
      logic [7:0]  pwm_period;
      logic [15:0] sample_edges;
   } cfg_type;

   typedef struct packed {
      logic               servo_drive;
      logic               sense_led;
      logic               reply_valid;
      logic signed [15:0] reply_value;
   } result_type;

endpackage

### sv/capacitive_dispense_controller_top.sv
// ----------------------------------------------------------------------------
// capacitive_dispense_controller_top
// Event-driven servo valve controller with capacitive level sensing.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one event word per handshake (measure tick, PWM tick, sense pin
//            change, host command). req_ready is high whenever the result
//            queue has room, so one word can be taken every cycle.
//   rsp_*  : exactly one result word per event, in order: servo pin level,
//            indicator level, and the reply for M, G and E commands.
//   csr_*  : register writes (index, data), always ready; write only while
//            the block is idle.
//   Path:    an accepted word is held in the input register, processed by
//            cdc_core and written into a two-entry result queue, from which
//            its result is offered. Throughput is one word per cycle while
//            the queue has room, set by the per-word state update in cdc_core.
//   Stall: with rsp_ready low the queue fills, then req_ready drops; nothing
//          is lost or repeated.
//   Reset: synchronous; clears the pipeline, loads register defaults and
//          the controller state (servo closed, wanted change 31).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "capacitive_dispense_controller_top_defines.svh"

module capacitive_dispense_controller_top import cdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic        req_pin_level,
   input  logic [7:0]  req_command,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_servo_drive,
   output logic        rsp_sense_led,
   output logic        rsp_reply_valid,
   output logic signed [15:0] rsp_reply_value,
   // register port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   opcode_type in_opcode_ff;
   logic       in_level_ff;
   logic [7:0] in_command_ff;
   result_type core_result;
   result_type queue_ff [2];
   logic       head_ff, tail_ff;
   logic [1:0] fill_ff, fill_in;
   logic       step;
   logic       pop;
   logic       room;
   logic       req_fire;

   // register file
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.closed_pulse <= RST_CLOSED_PULSE;
         cfg_ff.half_pulse   <= RST_HALF_PULSE;
         cfg_ff.open_pulse   <= RST_OPEN_PULSE;
         cfg_ff.pwm_period   <= RST_PWM_PERIOD;
         cfg_ff.sample_edges <= RST_SAMPLE_EDGES;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CLOSED_PULSE: cfg_ff.closed_pulse <= csr_data[7:0];
            CSR_HALF_PULSE:   cfg_ff.half_pulse   <= csr_data[7:0];
            CSR_OPEN_PULSE:   cfg_ff.open_pulse   <= csr_data[7:0];
            CSR_PWM_PERIOD:   cfg_ff.pwm_period   <= csr_data[7:0];
            CSR_SAMPLE_EDGES: cfg_ff.sample_edges <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline control
   assign pop       = rsp_valid && rsp_ready;
   assign room      = (fill_ff != 2'd2) || pop;
   assign step      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;
   assign req_fire  = req_valid && req_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_opcode_ff  <= opcode_type'(req_opcode);
         in_level_ff   <= req_pin_level;
         in_command_ff <= req_command;
      end
   end

   cdc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step_valid     (step),
      .step_opcode    (in_opcode_ff),
      .step_pin_level (in_level_ff),
      .step_command   (in_command_ff),
      .cfg            (cfg_ff),
      .result         (core_result)
   );

   // two-entry result queue
   always_comb begin
      fill_in = fill_ff;
      priority if (step && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!step && pop) begin
         fill_in = fill_ff - 2'd1;
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
         head_ff <= 1'b0;
         tail_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (step) tail_ff <= ~tail_ff;
         if (pop)  head_ff <= ~head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) queue_ff[tail_ff] <= core_result;
   end

   assign rsp_valid       = fill_ff != 2'd0;
   assign rsp_servo_drive = queue_ff[head_ff].servo_drive;
   assign rsp_sense_led   = queue_ff[head_ff].sense_led;
   assign rsp_reply_valid = queue_ff[head_ff].reply_valid;
   assign rsp_reply_value = queue_ff[head_ff].reply_value;

   // checks
   `CDC_ASSERT(a_fill_bound, fill_ff != 2'd3, "result queue over-filled")
   `CDC_ASSERT(a_no_overrun, step |-> (fill_ff != 2'd2) || pop, "queue written while full")
   `CDC_ASSERT(a_quiet_reply, (rsp_valid && !rsp_reply_valid) |-> (rsp_reply_value == 16'sd0), "reply value set without reply")
   `CDC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && !in_valid_ff, "pipeline not empty after reset")
   `CDC_ASSERT(a_ptr_match, (fill_ff == 2'd0) |-> (head_ff == tail_ff), "queue pointers disagree when empty")

endmodule

### sv/cdc_core.sv
// ----------------------------------------------------------------------------
// cdc_core
// Controller state and the per-event update; one event per enabled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdc_core import cdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,
   input  opcode_type step_opcode,
   input  logic       step_pin_level,
   input  logic [7:0] step_command,
   input  cfg_type    cfg,
   output result_type result
);

   logic [15:0]  edge_count_ff, edge_count_in;
   logic         window_done_ff, window_done_in;
   logic [15:0]  tick_count_ff, tick_count_in;
   logic [15:0]  capacitance_ff, capacitance_in;
   logic [15:0]  baseline_ff, baseline_in;
   logic [15:0]  wanted_ff, wanted_in;
   logic [15:0]  last_change_ff, last_change_in;
   logic [7:0]   pwm_phase_ff, pwm_phase_in;
   position_type position_ff, position_in;
   logic         dispensing_ff, dispensing_in;
   logic         servo_pin_ff, servo_pin_in;
   logic         led_toggle_ff, led_toggle_in;

   logic [15:0]  tick_inc;
   logic [15:0]  cap_new;
   logic [15:0]  diff;
   logic [15:0]  edge_inc;
   logic [7:0]   phase_inc;
   logic [15:0]  change;
   logic [7:0]   pulse;

   // pulse width of the current position
   always_comb begin
      unique case (position_ff)
         POS_HALF: pulse = cfg.half_pulse;
         POS_OPEN: pulse = cfg.open_pulse;
         default:  pulse = cfg.closed_pulse;
      endcase
   end

   assign tick_inc  = tick_count_ff + 16'd1;
   assign cap_new   = {1'b0, tick_inc[15:1]};
   assign diff      = baseline_ff - cap_new;
   assign edge_inc  = edge_count_ff + 16'd1;
   assign phase_inc = pwm_phase_ff + 8'd1;
   assign change    = baseline_ff - capacitance_ff;

   // event update
   always_comb begin
      edge_count_in  = edge_count_ff;
      window_done_in = window_done_ff;
      tick_count_in  = tick_count_ff;
      capacitance_in = capacitance_ff;
      baseline_in    = baseline_ff;
      wanted_in      = wanted_ff;
      last_change_in = last_change_ff;
      pwm_phase_in   = pwm_phase_ff;
      position_in    = position_ff;
      dispensing_in  = dispensing_ff;
      servo_pin_in   = servo_pin_ff;
      led_toggle_in  = led_toggle_ff;
      result.sense_led   = 1'b0;
      result.reply_valid = 1'b0;
      result.reply_value = 16'sd0;

      unique case (step_opcode)
         OP_MEASURE: begin
            tick_count_in = tick_inc;
            if (window_done_ff) begin
               capacitance_in = cap_new;
               tick_count_in  = 16'd0;
               edge_count_in  = 16'd0;
               window_done_in = 1'b0;
               // auto-close once the drop exceeds the wanted change
               if (dispensing_ff && ($signed(diff) > $signed(wanted_ff))) begin
                  last_change_in = diff;
                  position_in    = POS_CLOSED;
                  dispensing_in  = 1'b0;
               end
            end
         end
         OP_PWM: begin
            servo_pin_in = pwm_phase_ff < pulse;
            pwm_phase_in = (phase_inc == cfg.pwm_period) ? 8'd0 : phase_inc;
         end
         OP_SENSE: begin
            if (step_pin_level) begin
               result.sense_led = led_toggle_ff;
               led_toggle_in    = ~led_toggle_ff;
               edge_count_in    = edge_inc;
               window_done_in   = edge_inc > cfg.sample_edges;
            end
         end
         OP_COMMAND: begin
            unique case (step_command)
               CMD_DISPENSE: begin
                  baseline_in   = capacitance_ff;
                  position_in   = POS_OPEN;
                  dispensing_in = 1'b1;
               end
               CMD_CLOSE: position_in = POS_CLOSED;
               CMD_OPEN:  position_in = POS_OPEN;
               CMD_HALF:  position_in = POS_HALF;
               CMD_MEASURE: begin
                  result.reply_valid = 1'b1;
                  result.reply_value = $signed(capacitance_ff);
               end
               CMD_GET: begin
                  result.reply_valid = 1'b1;
                  result.reply_value = $signed(last_change_ff);
               end
               CMD_START: baseline_in = capacitance_ff;
               CMD_END: begin
                  result.reply_valid = 1'b1;
                  result.reply_value = $signed(change);
                  wanted_in          = change - 16'd1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      result.servo_drive = servo_pin_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff  <= 16'd0;
         window_done_ff <= 1'b0;
         tick_count_ff  <= 16'd0;
         capacitance_ff <= 16'd0;
         baseline_ff    <= 16'd0;
         wanted_ff      <= RST_WANTED;
         last_change_ff <= 16'd0;
         pwm_phase_ff   <= 8'd0;
         position_ff    <= POS_CLOSED;
         dispensing_ff  <= 1'b0;
         servo_pin_ff   <= 1'b0;
         led_toggle_ff  <= 1'b0;
      end else if (step_valid) begin
         edge_count_ff  <= edge_count_in;
         window_done_ff <= window_done_in;
         tick_count_ff  <= tick_count_in;
         capacitance_ff <= capacitance_in;
         baseline_ff    <= baseline_in;
         wanted_ff      <= wanted_in;
         last_change_ff <= last_change_in;
         pwm_phase_ff   <= pwm_phase_in;
         position_ff    <= position_in;
         dispensing_ff  <= dispensing_in;
         servo_pin_ff   <= servo_pin_in;
         led_toggle_ff  <= led_toggle_in;
      end
   end

endmodule

### tb/capacitive_dispense_controller_top_tb.sv
// ----------------------------------------------------------------------------
// Capacitive dispense controller testbench
// Sends measure ticks, PWM ticks, sense pin changes and host commands through
// the request channel under several register settings. Each result word is
// checked against a cycle-free model of the valve controller. Both channels
// idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module capacitive_dispense_controller_top_tb;
   import cdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 6;

   typedef struct {
      opcode_type op;
      logic       lvl;
      logic [7:0] cmd;
   } ctrl_event_t;

   logic clock;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic        req_pin_level = 1'b0;
   logic [7:0]  req_command = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_servo_drive;
   logic        rsp_sense_led;
   logic        rsp_reply_valid;
   logic signed [15:0] rsp_reply_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   capacitive_dispense_controller_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pin_level   (req_pin_level),
      .req_command     (req_command),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_servo_drive (rsp_servo_drive),
      .rsp_sense_led   (rsp_sense_led),
      .rsp_reply_valid (rsp_reply_valid),
      .rsp_reply_value (rsp_reply_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // words waiting to be sent, and result words owed by the block
   ctrl_event_t pending_events[$];
   result_type  due_results[$];
   result_type  oldest_due;

   // controller model state
   cfg_type      m_cfg;
   logic [15:0]  m_edges, m_ticks, m_cap, m_base, m_wanted, m_last;
   logic [7:0]   m_phase;
   position_type m_pos;
   logic         m_window, m_dispensing, m_pin, m_led;

   // handshakes seen at the last rising edge
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   cfg_type     plan_cfg;
   int          n_queued = 0;
   int          n_errors = 0;
   int          n_checked = 0;
   int          n_replies = 0;
   int          n_windows = 0;
   int          n_closures = 0;
   int          stall_cycles = 0;

   // sender and receiver pacing
   ctrl_event_t drv_item;
   logic        drv_pending = 1'b0;
   int          drv_gap = 0;
   int          req_calm = 0;
   int          rsp_calm = 0;
   int          rsp_wait = 0;

   // ------------------------------------------------------------------------
   // model
   // ------------------------------------------------------------------------
   function automatic result_type advance_controller(opcode_type op, logic lvl,
                                                     logic [7:0] cmd);
      result_type  word;
      logic [15:0] drop;
      logic [7:0]  pulse;
      word = '0;
      case (op)
         OP_MEASURE: begin
            m_ticks = m_ticks + 16'd1;
            if (m_window) begin
               n_windows++;
               m_cap    = m_ticks >> 1;
               m_ticks  = '0;
               m_edges  = '0;
               m_window = 1'b0;
               drop = m_base - m_cap;
               // level has fallen far enough: shut the valve
               if (m_dispensing && $signed(drop) > $signed(m_wanted)) begin
                  n_closures++;
                  m_last      = drop;
                  m_pos       = POS_CLOSED;
                  m_dispensing = 1'b0;
               end
            end
         end
         OP_PWM: begin
            if (m_pos == POS_HALF)      pulse = m_cfg.half_pulse;
            else if (m_pos == POS_OPEN) pulse = m_cfg.open_pulse;
            else                        pulse = m_cfg.closed_pulse;
            m_pin   = m_phase < pulse;
            m_phase = m_phase + 8'd1;
            if (m_phase == m_cfg.pwm_period) m_phase = '0;
         end
         OP_SENSE: begin
            if (lvl) begin
               word.sense_led = m_led;
               m_led    = ~m_led;
               m_edges  = m_edges + 16'd1;
               m_window = m_edges > m_cfg.sample_edges;
            end
         end
         default: begin
            case (cmd)
               CMD_DISPENSE: begin
                  m_base = m_cap;
                  m_pos  = POS_OPEN;
                  m_dispensing = 1'b1;
               end
               CMD_CLOSE: m_pos = POS_CLOSED;
               CMD_OPEN:  m_pos = POS_OPEN;
               CMD_HALF:  m_pos = POS_HALF;
               CMD_MEASURE: begin
                  word.reply_valid = 1'b1;
                  word.reply_value = m_cap;
               end
               CMD_GET: begin
                  word.reply_valid = 1'b1;
                  word.reply_value = m_last;
               end
               CMD_START: m_base = m_cap;
               CMD_END: begin
                  drop = m_base - m_cap;
                  word.reply_valid = 1'b1;
                  word.reply_value = drop;
                  m_wanted = drop - 16'd1;
               end
               default: ;
            endcase
         end
      endcase
      word.servo_drive = m_pin;
      return word;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      n_errors++;
      $display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   // random idle wait before a word, with occasional runs of back-to-back words
   function automatic int draw_wait(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   // ------------------------------------------------------------------------
   // rising edge: model update, result check, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         m_cfg        <= '{RST_CLOSED_PULSE, RST_HALF_PULSE, RST_OPEN_PULSE,
                           RST_PWM_PERIOD, RST_SAMPLE_EDGES};
         m_edges      = '0;
         m_ticks      = '0;
         m_cap        = '0;
         m_base       = '0;
         m_wanted     = RST_WANTED;
         m_last       = '0;
         m_phase      = '0;
         m_pos        = POS_CLOSED;
         m_window     = 1'b0;
         m_dispensing = 1'b0;
         m_pin        = 1'b0;
         m_led        = 1'b0;
         req_fire     <= 1'b0;
         rsp_fire     <= 1'b0;
         csr_fire     <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         rsp_fire <= rsp_valid && rsp_ready;
         csr_fire <= csr_valid && csr_ready;

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CLOSED_PULSE: m_cfg.closed_pulse <= csr_data[7:0];
               CSR_HALF_PULSE:   m_cfg.half_pulse   <= csr_data[7:0];
               CSR_OPEN_PULSE:   m_cfg.open_pulse   <= csr_data[7:0];
               CSR_PWM_PERIOD:   m_cfg.pwm_period   <= csr_data[7:0];
               CSR_SAMPLE_EDGES: m_cfg.sample_edges <= csr_data;
               default: ;
            endcase
         end

         if (req_valid && req_ready)
            due_results.push_back(advance_controller(opcode_type'(req_opcode),
                                                     req_pin_level, req_command));

         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("result word with none owed", 16'h0, 16'h0);
            end else begin
               oldest_due = due_results.pop_front();
               n_checked++;
               if (oldest_due.reply_valid) n_replies++;
               if (rsp_servo_drive !== oldest_due.servo_drive)
                  report_mismatch("servo_drive", 16'(rsp_servo_drive),
                                  16'(oldest_due.servo_drive));
               if (rsp_sense_led !== oldest_due.sense_led)
                  report_mismatch("sense_led", 16'(rsp_sense_led),
                                  16'(oldest_due.sense_led));
               if (rsp_reply_valid !== oldest_due.reply_valid)
                  report_mismatch("reply_valid", 16'(rsp_reply_valid),
                                  16'(oldest_due.reply_valid));
               if (rsp_reply_value !== oldest_due.reply_value)
                  report_mismatch("reply_value", rsp_reply_value, oldest_due.reply_value);
            end
         end

         // no handshake for too long: the block has hung
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // falling edge: request driver
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      logic nxt_valid;
      nxt_valid = req_valid;
      if (!reset) begin
         if (req_valid && req_fire) begin
            nxt_valid   = 1'b0;
            drv_pending = 1'b0;
         end
         if (!nxt_valid) begin
            if (!drv_pending && pending_events.size() != 0) begin
               drv_item    = pending_events.pop_front();
               drv_pending = 1'b1;
               drv_gap     = draw_wait(req_calm);
            end
            if (drv_pending) begin
               if (drv_gap > 0) begin
                  drv_gap--;
               end else begin
                  nxt_valid = 1'b1;
                  req_opcode    <= drv_item.op;
                  req_pin_level <= drv_item.lvl;
                  req_command   <= drv_item.cmd;
               end
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // falling edge: result receiver back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) rsp_wait = draw_wait(rsp_calm);
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_event(opcode_type op, logic lvl, logic [7:0] cmd);
      ctrl_event_t ev;
      ev.op  = op;
      ev.lvl = lvl;
      ev.cmd = cmd;
      pending_events.push_back(ev);
      // every queued word counts towards the phase size
      n_queued++;
   endtask

   task automatic push_cmd(logic [7:0] cmd);
      push_event(OP_COMMAND, 1'($urandom_range(0, 1)), cmd);
   endtask

   task automatic push_tick(opcode_type op);
      push_event(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endtask

   task automatic push_sense(logic lvl);
      push_event(OP_SENSE, lvl, 8'($urandom_range(0, 255)));
   endtask

   function automatic logic [7:0] pick_command();
      case ($urandom_range(0, 9))
         0: return CMD_DISPENSE;
         1: return CMD_CLOSE;
         2: return CMD_OPEN;
         3: return CMD_HALF;
         4: return CMD_MEASURE;
         5: return CMD_GET;
         6: return CMD_START;
         7: return CMD_END;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one measurement window: rising edges (enough to close it when sample_edges
   // is below 16) interleaved with ticks and other traffic, then the tick that turns the count into a capacitance
   task automatic gen_window();
      int edges_left;
      int ticks_left;
      edges_left = (plan_cfg.sample_edges < 16) ? plan_cfg.sample_edges + 1
                                                : $urandom_range(1, 8);
      ticks_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                               : $urandom_range(0, 60);
      case ($urandom_range(0, 4))
         0, 1: push_cmd(CMD_DISPENSE);
         2:    push_cmd(CMD_START);
         default: ;
      endcase
      while (edges_left > 0 || ticks_left > 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: if (ticks_left > 0) begin
               push_tick(OP_MEASURE);
               ticks_left--;
            end
            4, 5, 6: if (edges_left > 0) begin
               push_sense(1'b1);
               edges_left--;
            end
            7: push_tick(OP_PWM);
            8: push_sense(1'b0);
            default: push_cmd(pick_command());
         endcase
      end
      push_tick(OP_MEASURE);
      case ($urandom_range(0, 5))
         0: push_cmd(CMD_END);
         1: push_cmd(CMD_GET);
         2: push_cmd(CMD_MEASURE);
         default: ;
      endcase
   endtask

   task automatic push_noise();
      opcode_type op;
      op = opcode_type'($urandom_range(0, 3));
      if (op == OP_COMMAND && $urandom_range(0, 3) != 0)
         push_cmd(pick_command());
      else
         push_event(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endtask

   task automatic fill_phase(int target);
      int goal;
      goal = n_queued + target;
      while (n_queued < goal) begin
         if ($urandom_range(0, 9) < 7) gen_window();
         else repeat ($urandom_range(1, 12)) push_noise();
      end
   endtask

   // called at a falling edge; returns at a falling edge
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      while (!csr_fire) @(negedge clock);
   endtask

   task automatic apply_settings(cfg_type c);
      write_reg(CSR_CLOSED_PULSE, {8'h00, c.closed_pulse});
      write_reg(CSR_HALF_PULSE,   {8'h00, c.half_pulse});
      write_reg(CSR_OPEN_PULSE,   {8'h00, c.open_pulse});
      write_reg(CSR_PWM_PERIOD,   {8'h00, c.pwm_period});
      write_reg(CSR_SAMPLE_EDGES, c.sample_edges);
      csr_valid <= 1'b0;
      plan_cfg = c;
   endtask

   // hold the sender until every owed result word is back
   task automatic wait_drained();
      while (pending_events.size() != 0 || drv_pending || req_valid ||
             due_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic cfg_type make_cfg(int c, int h, int o, int p, int s);
      cfg_type r;
      r.closed_pulse = c[7:0];
      r.half_pulse   = h[7:0];
      r.open_pulse   = o[7:0];
      r.pwm_period   = p[7:0];
      r.sample_edges = s[15:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      cfg_type plans[7];
      int      targets[7];

      rsp_wait = draw_wait(rsp_calm);
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: replies at reset, each position, a window and an auto close
      apply_settings(make_cfg(255, 0, 7, 3, 1));
      push_cmd(CMD_MEASURE);
      push_cmd(CMD_GET);
      push_cmd(CMD_END);                    // wanted change becomes -1
      push_tick(OP_PWM);
      push_cmd(CMD_HALF);
      push_tick(OP_PWM);
      push_cmd(CMD_OPEN);
      push_tick(OP_PWM);
      push_tick(OP_MEASURE);
      push_tick(OP_MEASURE);
      push_tick(OP_MEASURE);
      push_sense(1'b0);                     // falling level: ignored
      push_sense(1'b1);
      push_sense(1'b1);
      push_tick(OP_MEASURE);                // capacitance 2
      push_cmd(CMD_START);
      push_cmd(CMD_DISPENSE);
      push_sense(1'b1);
      push_sense(1'b1);
      push_tick(OP_MEASURE);                // drop of 2 closes the valve
      push_cmd(CMD_GET);
      push_cmd(CMD_END);
      push_cmd(CMD_CLOSE);
      push_cmd(8'h00);
      push_cmd(8'hFF);
      wait_drained();

      // random phases; period zero, a small period after a large one and
      // windows that never close are among them
      plans[0] = make_cfg(21, 14, 7, 200, 2);
      plans[1] = make_cfg(0, 255, 128, 255, 3);
      plans[2] = make_cfg(200, 100, 50, 1, 1);
      plans[3] = make_cfg(5, 10, 15, 0, 4);
      plans[4] = make_cfg(255, 255, 255, 20, 65534);
      plans[5] = make_cfg(21, 14, 7, 200, 65535);
      plans[6] = make_cfg($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(1, 255),
                          $urandom_range(1, 6));
      // each phase overshoots its target by part of a window
      targets  = '{180, 180, 180, 180, 90, 90, 180};

      foreach (plans[i]) begin
         apply_settings(plans[i]);
         fill_phase(targets[i]);
         wait_drained();
      end

      $display("Checked %0d result words, %0d of them replies, over eight settings.",
               n_checked, n_replies);
      $display("Model saw %0d measurement windows and %0d automatic valve closures.",
               n_windows, n_closures);
      if (n_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
